// ===== design/mwpo_pkg.sv =====
package mwpo_pkg;

    // Core sizes
    localparam int SINE_TABLE_BITS = 8;
    localparam int OUTPUT_BITS     = 16;
    localparam int FREQ_W          = 16;
    localparam int STEP_SCALE_W    = 24;
    localparam int WAVE_W          = 3;
    localparam int PHASE_W         = 32;
    localparam int LFSR_W          = 32;
    // signed frequency times unsigned scale
    localparam int STEP_W          = FREQ_W + STEP_SCALE_W;
    // phase plus step, with room for the wrap count and sign
    localparam int SUM_W           = STEP_W + 1;

    // Quarter-wave sine table
    localparam int QSIZE       = 1 << SINE_TABLE_BITS;
    localparam int SINE_ADDR_W = SINE_TABLE_BITS + 1;
    localparam int MAG_W       = OUTPUT_BITS - 1;
    localparam longint FULL    = longint'(1) << (OUTPUT_BITS - 1);

    // Port widths
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = STEP_SCALE_W;
    localparam int S_DATA_W   = ((FREQ_W + 7) / 8) * 8;
    localparam int M_DATA_W   = ((OUTPUT_BITS + 7) / 8) * 8;

    // Decoupling queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Reset values and fixed constants
    localparam logic [STEP_SCALE_W-1:0] HZ_TO_STEP_RESET = 24'd89478;
    localparam logic [LFSR_W-1:0]       LFSR_SEED        = 32'hACE1_ACE1;
    localparam logic [LFSR_W-1:0]       LFSR_TAPS        = 32'h8020_0003;
    localparam logic [PHASE_W-1:0]      PHASE_HALF       = 32'h8000_0000;
    localparam logic [63:0]             HALF_PI_Q30      = 64'd1686629713;

    // Waveform selector codes
    typedef enum logic [WAVE_W-1:0] {
        WAVE_SILENT   = 3'd0,
        WAVE_SINE     = 3'd1,
        WAVE_TRIANGLE = 3'd2,
        WAVE_SAW      = 3'd3,
        WAVE_SQUARE   = 3'd4,
        WAVE_NOISE    = 3'd5
    } wave_t;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_WAVEFORM   = 1'b0,
        CFG_HZ_TO_STEP = 1'b1
    } cfg_reg_t;

    // One queued item: phase step plus resolved waveform
    typedef struct packed {
        logic signed [STEP_W-1:0] step;
        wave_t                    wave;
    } queue_item_t;

    typedef logic [MAG_W-1:0] quarter_tbl_t [0:QSIZE];

    // Quarter-wave table, Taylor series in Q30, evaluated at elaboration
    function automatic quarter_tbl_t build_quarter_table();
        quarter_tbl_t tbl;
        logic [63:0]  x;
        logic [63:0]  x2;
        logic [63:0]  term;
        logic [63:0]  sum;
        logic [63:0]  scaled;
        for (int k = 0; k <= QSIZE; k++) begin
            x    = (64'(k) * HALF_PI_Q30) / QSIZE;
            x2   = (x * x) >> 30;
            term = x;
            sum  = x;
            term = ((term * x2) >> 30) / 6;
            sum  = (sum >= term) ? sum - term : 64'd0;
            term = ((term * x2) >> 30) / 20;
            sum  = sum + term;
            term = ((term * x2) >> 30) / 42;
            sum  = (sum >= term) ? sum - term : 64'd0;
            term = ((term * x2) >> 30) / 72;
            sum  = sum + term;
            term = ((term * x2) >> 30) / 110;
            sum  = (sum >= term) ? sum - term : 64'd0;
            term = ((term * x2) >> 30) / 156;
            sum  = sum + term;
            term = ((term * x2) >> 30) / 210;
            sum  = (sum >= term) ? sum - term : 64'd0;
            if (sum > (64'd1 << 30)) begin
                sum = 64'd1 << 30;
            end
            scaled = (sum * 64'(FULL - 1) + (64'd1 << 29)) >> 30;
            tbl[k] = scaled[MAG_W-1:0];
        end
        return tbl;
    endfunction

    localparam quarter_tbl_t SINE_QUARTER = build_quarter_table();

    // One step of the Galois LFSR, shifting right
    function automatic logic [LFSR_W-1:0] lfsr_advance(input logic [LFSR_W-1:0] cur);
        logic [LFSR_W-1:0] nxt;
        nxt = cur >> 1;
        if (cur[0]) begin
            nxt = nxt ^ LFSR_TAPS;
        end
        return nxt;
    endfunction

endpackage

// ===== design/multi_waveform_phase_oscillator_core.sv =====
// Direct digital synthesis oscillator. Each s_ transfer carries a signed
// frequency in hertz; the core multiplies it by hz_to_step, adds the product
// to a 32-bit phase accumulator (modulo one cycle) and returns one signed
// Q1.15 sample of the selected waveform on the m_ side: silence, sine
// (quarter-wave table, no interpolation), triangle, saw, square or held LFSR
// noise that redraws whenever the accumulator wraps. Silence leaves the phase
// where it is. The core takes one transfer per clock while the queue has room
// and returns results in order: the multiplier in the front end feeds a
// four-entry queue, then the phase register and the output register. The
// phase add, looping through the phase register, sets the one-per-clock rate.
// Write waveform (index 0) and hz_to_step (index 1) only while the core holds
// no pending items.
module multi_waveform_phase_oscillator_core import mwpo_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration writes
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // Frequency input
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // [15:0] frequency_hz
    // Sample output
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata    // [OUTPUT_BITS-1:0] sample
);

    logic [WAVE_W-1:0]       waveform_reg;
    logic [STEP_SCALE_W-1:0] hz_to_step_reg;

    logic                   q_full, q_push, q_pop, q_valid;
    queue_item_t            push_item, head_item;
    logic [OUTPUT_BITS-1:0] sample;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            waveform_reg   <= WAVE_SILENT;
            hz_to_step_reg <= HZ_TO_STEP_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_addr))
                CFG_WAVEFORM:   waveform_reg   <= cfg_wdata[WAVE_W-1:0];
                CFG_HZ_TO_STEP: hz_to_step_reg <= cfg_wdata[STEP_SCALE_W-1:0];
                default:        ;
            endcase
        end
    end

    mwpo_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .waveform   (waveform_reg),
        .hz_to_step (hz_to_step_reg),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_item     (push_item)
    );

    mwpo_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_item  (push_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_item  (head_item)
    );

    mwpo_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_item     (head_item),
        .q_pop      (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_sample (sample)
    );

    // Pad the sample up to whole bytes
    always_comb begin
        m_tdata                  = '0;
        m_tdata[OUTPUT_BITS-1:0] = sample;
    end

endmodule

// ===== design/mwpo_front.sv =====
module mwpo_front import mwpo_pkg::*; (
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [S_DATA_W-1:0]     s_tdata,
    input  logic [WAVE_W-1:0]       waveform,
    input  logic [STEP_SCALE_W-1:0] hz_to_step,
    input  logic                    q_full,
    output logic                    q_push,
    output queue_item_t             q_item
);

    logic signed [FREQ_W-1:0] freq;
    logic signed [STEP_W-1:0] prod;
    wave_t                    wave;

    // Accept whenever the queue has room
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    // Phase step: signed frequency times unsigned scale
    always_comb begin
        freq = $signed(s_tdata[FREQ_W-1:0]);
        prod = freq * $signed({1'b0, hz_to_step});
    end

    // Resolve the selector; unused codes run silent
    always_comb begin
        case (waveform)
            WAVE_SINE:     wave = WAVE_SINE;
            WAVE_TRIANGLE: wave = WAVE_TRIANGLE;
            WAVE_SAW:      wave = WAVE_SAW;
            WAVE_SQUARE:   wave = WAVE_SQUARE;
            WAVE_NOISE:    wave = WAVE_NOISE;
            default:       wave = WAVE_SILENT;
        endcase
    end

    always_comb begin
        q_item.step = prod;
        q_item.wave = wave;
    end

endmodule

// ===== design/mwpo_queue.sv =====
module mwpo_queue import mwpo_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  queue_item_t push_item,
    output logic        full,
    input  logic        pop,
    output logic        head_valid,
    output queue_item_t head_item
);

    queue_item_t       mem_reg [0:QUEUE_DEPTH-1];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = mem_reg[rd_ptr_reg];

    // Pointer and fill count
    always_comb begin
        wr_ptr_next = push ? QPTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop  ? QPTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = QCNT_W'(count_reg + 1'b1);
        end else if (pop && !push) begin
            count_next = QCNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== design/mwpo_back.sv =====
module mwpo_back import mwpo_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   q_valid,
    input  queue_item_t            q_item,
    output logic                   q_pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [OUTPUT_BITS-1:0] out_sample
);

    localparam int TRI_W = OUTPUT_BITS + 2;
    localparam logic signed [TRI_W-1:0] TRI_FULL   = TRI_W'(FULL);
    localparam logic signed [TRI_W-1:0] TRI_THREE  = TRI_W'(3 * FULL);
    localparam logic signed [TRI_W-1:0] TRI_MAX    = TRI_W'(FULL - 1);
    localparam logic [OUTPUT_BITS-1:0]  SAMPLE_MAX = OUTPUT_BITS'(FULL - 1);
    localparam logic [OUTPUT_BITS-1:0]  SAMPLE_MIN = OUTPUT_BITS'(FULL);

    // Phase stage
    logic [PHASE_W-1:0]     phase_reg, phase_next;
    logic                   s1_valid_reg, s1_valid_next;
    wave_t                  s1_wave_reg;
    logic                   s1_wrap_reg;
    // Output stage and noise state
    logic                   out_valid_reg, out_valid_next;
    logic [OUTPUT_BITS-1:0] sample_reg, sample_next;
    logic [LFSR_W-1:0]      lfsr_reg, lfsr_adv;
    logic [OUTPUT_BITS-1:0] hold_reg, noise_new, noise_val;

    logic                   out_free, s1_free, s1_move;
    logic signed [SUM_W-1:0] full_sum;
    logic                   wrapped;
    logic                   noise_take;

    logic [1:0]                 quad;
    logic [SINE_TABLE_BITS-1:0] idx;
    logic [SINE_ADDR_W-1:0]     sine_addr;
    logic [MAG_W-1:0]           mag;
    logic [OUTPUT_BITS-1:0]     sine_val, tri_val, saw_val, square_val;
    logic                       half_or_less;
    logic [OUTPUT_BITS:0]       tri_u;
    logic signed [TRI_W-1:0]    tri_v;

    // Stage flow control
    assign out_free  = !out_valid_reg || out_ready;
    assign s1_free   = !s1_valid_reg || out_free;
    assign s1_move   = s1_valid_reg && out_free;
    assign q_pop     = q_valid && s1_free;
    assign out_valid  = out_valid_reg;
    assign out_sample = sample_reg;

    // Phase accumulate and wrap detect
    always_comb begin
        full_sum   = SUM_W'($signed({1'b0, phase_reg})) + SUM_W'(q_item.step);
        wrapped    = (full_sum[SUM_W-1:PHASE_W] != '0);
        phase_next = phase_reg;
        if (q_pop && (q_item.wave != WAVE_SILENT)) begin
            phase_next = full_sum[PHASE_W-1:0];
        end
        s1_valid_next = q_pop || (s1_valid_reg && !s1_move);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            s1_wave_reg <= q_item.wave;
            s1_wrap_reg <= wrapped;
        end
    end

    // Sine from the quarter-wave table
    always_comb begin
        quad      = phase_reg[PHASE_W-1 -: 2];
        idx       = phase_reg[PHASE_W-3 -: SINE_TABLE_BITS];
        sine_addr = quad[0] ? SINE_ADDR_W'(QSIZE) - {1'b0, idx} : {1'b0, idx};
        mag       = SINE_QUARTER[sine_addr];
        sine_val  = quad[1] ? OUTPUT_BITS'(-{1'b0, mag}) : {1'b0, mag};
    end

    // Triangle, saw and square
    always_comb begin
        half_or_less = (phase_reg <= PHASE_HALF);
        tri_u        = phase_reg[PHASE_W-1 -: OUTPUT_BITS+1];
        if (half_or_less) begin
            tri_v = $signed({1'b0, tri_u}) - TRI_FULL;
        end else begin
            tri_v = TRI_THREE - $signed({1'b0, tri_u});
        end
        if (tri_v > TRI_MAX) begin
            tri_v = TRI_MAX;
        end
        tri_val    = tri_v[OUTPUT_BITS-1:0];
        saw_val    = {~phase_reg[PHASE_W-1], phase_reg[PHASE_W-2 -: OUTPUT_BITS-1]};
        square_val = half_or_less ? SAMPLE_MIN : SAMPLE_MAX;
    end

    // Noise: new draw on each wrap, else hold
    always_comb begin
        lfsr_adv   = lfsr_advance(lfsr_reg);
        noise_new  = {~lfsr_adv[LFSR_W-1], lfsr_adv[LFSR_W-2 -: OUTPUT_BITS-1]};
        noise_take = s1_wrap_reg && (s1_wave_reg == WAVE_NOISE);
        noise_val  = noise_take ? noise_new : hold_reg;
    end

    // Sample select
    always_comb begin
        case (s1_wave_reg)
            WAVE_SINE:     sample_next = sine_val;
            WAVE_TRIANGLE: sample_next = tri_val;
            WAVE_SAW:      sample_next = saw_val;
            WAVE_SQUARE:   sample_next = square_val;
            WAVE_NOISE:    sample_next = noise_val;
            default:       sample_next = '0;
        endcase
        out_valid_next = s1_move || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            lfsr_reg      <= LFSR_SEED;
            hold_reg      <= '0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (s1_move && noise_take) begin
                lfsr_reg <= lfsr_adv;
                hold_reg <= noise_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_move) begin
            sample_reg <= sample_next;
        end
    end

endmodule

// ===== design/mwpo_checker.sv =====
module mwpo_checker import mwpo_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_DATA_W-1:0]   m_tdata
);

    // A stalled result stays offered with the same data
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed while stalled");

    // No result comes out of reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // Input side only backs up when a result is waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

    // A transfer into an empty core shows up only after the queue, phase and output registers
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid && s_tready && !$past(s_tvalid && s_tready)
            && !$past(s_tvalid && s_tready, 2) && s_tvalid |=> ##1 !m_tvalid)
        else $error("result earlier than expected latency");

endmodule

bind multi_waveform_phase_oscillator_core mwpo_checker u_mwpo_checker (.*);
